// ===== rtl/core/npls_pkg.sv =====
// Package for the nearest point search unit: state type, field widths and codes.
package npls_pkg;

   localparam int INDEX_W  = 12;
   localparam int DIST_W   = 34;
   localparam int STATUS_W = 2;

   localparam logic [DIST_W-1:0] DIST_MAX     = 34'h3_FFFF_FFFF;
   localparam logic [DIST_W-1:0] RADIUS_RESET = 34'd100000000;

   localparam logic CMD_APPEND = 1'b0;
   localparam logic CMD_QUERY  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NONE = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

// ===== rtl/core/npls_ram.sv =====
// Generic simple dual-port RAM with registered read.
module npls_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/nearest_point_linear_search_unit.sv =====
// Top level: brute-force 2-D nearest point search over a RAM-backed point store.
// Append: the unit goes through ST_DONE to the registered response, then back to ST_IDLE.
// Query: the unit goes through ST_SCAN (no reads on an empty store) and ST_DONE to the response
// register, then back to ST_IDLE; in ST_SCAN one stored point is read per cycle, then two
// distance stages and a compare follow. A waiting result stalls input.
// Synchronous reset clears the point count, radius (to 100000000) and control.
module nearest_point_linear_search_unit #(
   parameter int MAX_POINTS = 4096,
   parameter int COORD_BITS = 16
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           req_tvalid,
   output logic                                           req_tready,
   // point_x, point_y
   input  logic [((2*COORD_BITS+7)/8)*8-1:0]              req_tdata,
   // cmd
   input  logic                                           req_tuser,
   output logic                                           rsp_tvalid,
   input  logic                                           rsp_tready,
   // nearest_index, nearest_dist_sq
   output logic [((npls_pkg::INDEX_W+npls_pkg::DIST_W+7)/8)*8-1:0] rsp_tdata,
   // status
   output logic [npls_pkg::STATUS_W-1:0]                  rsp_tuser,
   input  logic                                           csr_valid,
   output logic                                           csr_ready,
   input  logic [npls_pkg::DIST_W-1:0]                    csr_data
);

   import npls_pkg::*;

   localparam int IDX_W   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W   = $clog2(MAX_POINTS + 1);
   localparam int PT_W    = 2 * COORD_BITS;
   localparam int SQ_W    = 2 * COORD_BITS;
   localparam int EXT_W   = (SQ_W + 1 > DIST_W) ? SQ_W + 1 : DIST_W;
   localparam int RSP_W   = ((INDEX_W + DIST_W + 7) / 8) * 8;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]             count_ff;
   logic [DIST_W-1:0]            radius_ff;
   logic signed [COORD_BITS-1:0] qx_ff, qy_ff;
   logic [CNT_W-1:0]             issue_ff;
   logic [DIST_W-1:0]            limit_ff;
   logic                         found_ff;
   logic [IDX_W-1:0]             found_idx_ff;

   logic                         rv_ff, dv_ff, sv_ff;
   logic [IDX_W-1:0]             ridx_ff, didx_ff, sidx_ff;
   logic [COORD_BITS-1:0]        dx_ff, dy_ff;
   logic [SQ_W-1:0]              sx_ff, sy_ff;

   logic [STATUS_W-1:0]          res_status_ff;
   logic [INDEX_W-1:0]           res_index_ff;
   logic [DIST_W-1:0]            res_dist_ff;

   logic                         rsp_valid_ff;
   logic [STATUS_W-1:0]          rsp_status_ff;
   logic [INDEX_W-1:0]           rsp_index_ff;
   logic [DIST_W-1:0]            rsp_dist_ff;

   logic                         req_accept;
   logic                         rd_en;
   logic                         scan_end;
   logic                         out_free;
   logic                         store_full;
   logic                         wr_en;
   logic [PT_W-1:0]              rd_data;

   logic signed [COORD_BITS-1:0] px, py;
   logic signed [COORD_BITS:0]   diff_x, diff_y;
   logic [COORD_BITS-1:0]        dx_in, dy_in;
   logic [EXT_W-1:0]             sum_ext;
   logic [DIST_W-1:0]            scan_dist_sq;

   // Control outputs
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      rd_en      = (state_ff == ST_SCAN) && (issue_ff < count_ff);
      scan_end   = (state_ff == ST_SCAN) && (issue_ff == count_ff) &&
                   !rv_ff && !dv_ff && !sv_ff;
      out_free   = !rsp_valid_ff || rsp_tready;
   end

   assign req_accept = req_tvalid && req_tready;
   assign store_full = (count_ff == CNT_W'(MAX_POINTS));
   assign wr_en      = req_accept && (req_tuser == CMD_APPEND) && !store_full;
   assign csr_ready  = 1'b1;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = (req_tuser == CMD_APPEND) ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_end) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   npls_ram #(
      .WIDTH (PT_W),
      .DEPTH (MAX_POINTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (req_tdata[PT_W-1:0]),
      .rd_en   (rd_en),
      .rd_addr (issue_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // Distance datapath
   always_comb begin
      px      = rd_data[COORD_BITS-1:0];
      py      = rd_data[PT_W-1:COORD_BITS];
      diff_x  = {px[COORD_BITS-1], px} - {qx_ff[COORD_BITS-1], qx_ff};
      diff_y  = {py[COORD_BITS-1], py} - {qy_ff[COORD_BITS-1], qy_ff};
      dx_in   = diff_x[COORD_BITS] ? COORD_BITS'(-diff_x) : diff_x[COORD_BITS-1:0];
      dy_in   = diff_y[COORD_BITS] ? COORD_BITS'(-diff_y) : diff_y[COORD_BITS-1:0];
      sum_ext = EXT_W'(sx_ff) + EXT_W'(sy_ff);
      scan_dist_sq = (sum_ext > EXT_W'(DIST_MAX)) ? DIST_MAX : sum_ext[DIST_W-1:0];
   end

   always_ff @(posedge clock) begin
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      sx_ff   <= SQ_W'(dx_ff) * SQ_W'(dx_ff);
      sy_ff   <= SQ_W'(dy_ff) * SQ_W'(dy_ff);
      ridx_ff <= issue_ff[IDX_W-1:0];
      didx_ff <= ridx_ff;
      sidx_ff <= didx_ff;
      if (req_accept) begin
         qx_ff <= req_tdata[COORD_BITS-1:0];
         qy_ff <= req_tdata[PT_W-1:COORD_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         radius_ff     <= RADIUS_RESET;
         issue_ff      <= '0;
         limit_ff      <= '0;
         found_ff      <= 1'b0;
         found_idx_ff  <= '0;
         rv_ff         <= 1'b0;
         dv_ff         <= 1'b0;
         sv_ff         <= 1'b0;
         res_status_ff <= STATUS_OK;
         res_index_ff  <= '0;
         res_dist_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_status_ff <= STATUS_OK;
         rsp_index_ff  <= '0;
         rsp_dist_ff   <= '0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rd_en;
         dv_ff    <= rv_ff;
         sv_ff    <= dv_ff;

         if (csr_valid && csr_ready) begin
            radius_ff <= csr_data;
         end

         if (req_accept) begin
            issue_ff <= '0;
            limit_ff <= radius_ff;
            found_ff <= 1'b0;
            if (req_tuser == CMD_APPEND) begin
               res_dist_ff <= '0;
               if (store_full) begin
                  res_status_ff <= STATUS_FULL;
                  res_index_ff  <= '0;
               end else begin
                  res_status_ff <= STATUS_OK;
                  res_index_ff  <= INDEX_W'(count_ff);
                  count_ff      <= count_ff + 1'b1;
               end
            end
         end

         if (rd_en) begin
            issue_ff <= issue_ff + 1'b1;
         end

         if (sv_ff && (scan_dist_sq < limit_ff)) begin
            limit_ff     <= scan_dist_sq;
            found_idx_ff <= sidx_ff;
            found_ff     <= 1'b1;
         end

         if (scan_end) begin
            if (found_ff) begin
               res_status_ff <= STATUS_OK;
               res_index_ff  <= INDEX_W'(found_idx_ff);
               res_dist_ff   <= limit_ff;
            end else begin
               res_status_ff <= STATUS_NONE;
               res_index_ff  <= '0;
               res_dist_ff   <= '0;
            end
         end

         if ((state_ff == ST_DONE) && out_free) begin
            rsp_valid_ff  <= 1'b1;
            rsp_status_ff <= res_status_ff;
            rsp_index_ff  <= res_index_ff;
            rsp_dist_ff   <= res_dist_ff;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = RSP_W'({rsp_dist_ff, rsp_index_ff});

endmodule
